>>> design/cssu_pkg.sv
// ----------------------------------------------------------------------------
// cssu_pkg
// Shared types and constants of the counter scan unit: item kinds, field
// widths, the divide-by-ten reciprocal and the seven-segment decoder.
// ----------------------------------------------------------------------------
package cssu_pkg;

    localparam int ENABLE_BITS  = 5;
    localparam int SEG_BITS     = 8;
    localparam int LOAD_BITS    = 16;
    localparam int WIDE_BITS    = 32;
    localparam int QUEUE_DEPTH  = 2;

    // Quotient of x / 10 is (x * DIV10_MUL) >> DIV10_SHIFT for any 32-bit x.
    localparam logic [WIDE_BITS-1:0] DIV10_MUL   = 32'hCCCC_CCCD;
    localparam int                   DIV10_SHIFT = 35;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_LOAD   = 1'b1
    } t_kind;

    localparam logic BUTTON_PRESSED = 1'b0;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    function automatic logic [SEG_BITS-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_BITS-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'b1101_1101;
            4'd1:    pat = 8'b0101_0000;
            4'd2:    pat = 8'b1001_1011;
            4'd3:    pat = 8'b1101_1010;
            4'd4:    pat = 8'b0101_0110;
            4'd5:    pat = 8'b1100_1110;
            4'd6:    pat = 8'b1100_1111;
            4'd7:    pat = 8'b0101_1000;
            4'd8:    pat = 8'b1101_1111;
            4'd9:    pat = 8'b1101_1110;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

>>> design/cssu_if.sv
// ----------------------------------------------------------------------------
// cssu_if
// Valid/ready channels of the counter scan unit: input items and digit results.
// ----------------------------------------------------------------------------
interface cssu_in_if
    import cssu_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic                 button_level;
    logic [LOAD_BITS-1:0] load_value;

    modport source (output valid, kind, button_level, load_value, input ready);
    modport sink   (input valid, kind, button_level, load_value, output ready);
endinterface

interface cssu_out_if
    import cssu_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [ENABLE_BITS-1:0] digit_enable;
    logic [SEG_BITS-1:0]    segments;
    logic                   last;

    modport source (output valid, digit_enable, segments, last, input ready);
    modport sink   (input valid, digit_enable, segments, last, output ready);
endinterface

>>> design/cssu_front.sv
// ----------------------------------------------------------------------------
// cssu_front
// Accepts items, updates the event count and queues a snapshot of the count
// for the scan engine.
// ----------------------------------------------------------------------------
module cssu_front
    import cssu_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cssu_in_if.sink               i_item,
    input  t_queue_stat           i_stat,
    output logic                  o_push,
    output logic [COUNT_BITS-1:0] o_push_data
);

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [WIDE_BITS-1:0]  w_load_wide;
    logic                  w_accept;

    assign i_item.ready = !i_stat.full;
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_load_wide  = {{(WIDE_BITS - LOAD_BITS){1'b0}}, i_item.load_value};

    always_comb begin
        n_count = r_count;
        if (i_item.kind == KIND_LOAD) begin
            n_count = w_load_wide[COUNT_BITS-1:0];
        end else if (i_item.button_level == BUTTON_PRESSED) begin
            n_count = r_count + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    assign o_push      = w_accept;
    assign o_push_data = n_count;

endmodule

>>> design/cssu_queue.sv
// ----------------------------------------------------------------------------
// cssu_queue
// Two-entry queue of count snapshots between the front end and the scan engine.
// ----------------------------------------------------------------------------
module cssu_queue
    import cssu_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output t_queue_stat      o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    assign o_pop_data  = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from an empty queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

>>> design/cssu_back.sv
// ----------------------------------------------------------------------------
// cssu_back
// Scan engine: splits a count snapshot into decimal digits, one per cycle while
// the results are taken, and drives the registered digit results.
// ----------------------------------------------------------------------------
module cssu_back
    import cssu_pkg::*;
#(
    parameter int NUM_DIGITS = 5,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_queue_stat           i_stat,
    input  logic [COUNT_BITS-1:0] i_pop_data,
    output logic                  o_pop,
    cssu_out_if.source            o_result
);

    localparam int                IDX_W    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_DIGITS - 1);
    localparam int                PROD_W   = 2 * WIDE_BITS;

    logic                     r_busy;
    logic [COUNT_BITS-1:0]    r_rest;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_out_valid;
    logic [ENABLE_BITS-1:0]   r_out_en;
    logic [SEG_BITS-1:0]      r_out_seg;
    logic                     r_out_last;

    logic [PROD_W-1:0]        w_prod;
    logic [COUNT_BITS-1:0]    w_quot;
    logic [COUNT_BITS+3:0]    w_quot10;
    logic [COUNT_BITS+3:0]    w_diff;
    logic [3:0]               w_digit;
    logic [ENABLE_BITS-1:0]   w_en;
    logic                     w_step;
    logic                     w_finish;

    assign w_prod   = PROD_W'({{(WIDE_BITS - COUNT_BITS){1'b0}}, r_rest}) * PROD_W'(DIV10_MUL);
    assign w_quot   = w_prod[DIV10_SHIFT +: COUNT_BITS];
    assign w_quot10 = {1'b0, w_quot, 3'b000} + {3'b000, w_quot, 1'b0};
    assign w_diff   = {4'b0000, r_rest} - w_quot10;
    assign w_digit  = w_diff[3:0];
    assign w_en     = (int'(r_idx) < ENABLE_BITS) ? (ENABLE_BITS'(1) << r_idx) : '0;

    assign w_step   = r_busy && (!r_out_valid || o_result.ready);
    assign w_finish = w_step && (r_idx == LAST_IDX);
    assign o_pop    = !i_stat.empty && (!r_busy || w_finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end else if (w_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rest <= i_pop_data;
        end else if (w_step) begin
            r_rest <= w_quot;
        end
        if (w_step) begin
            r_out_en   <= w_en;
            r_out_seg  <= seg_pattern(w_digit);
            r_out_last <= (r_idx == LAST_IDX);
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.digit_enable = r_out_en;
    assign o_result.segments     = r_out_seg;
    assign o_result.last         = r_out_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= LAST_IDX))
        else $error("digit index beyond the scan pass");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || w_finish))
        else $error("new snapshot taken in the middle of a scan pass");

    a_pass_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_busy && r_idx == '0))
        else $error("scan pass did not start at the units digit");

endmodule

>>> design/counter_seven_segment_scan_unit.sv
// ----------------------------------------------------------------------------
// counter_seven_segment_scan_unit
// Event counter with a decimal seven-segment scan: every item may update the
// count and yields one scan pass of digit results, units digit first.
//
//   Channel    Dir  Handshake      Payload
//   i_item     in   valid/ready    kind, button_level, load_value
//   o_result   out  valid/ready    digit_enable, segments, last
//
// Each item's scan pass leaves at one result per cycle while o_result does not
// stall, set by the one-digit-per-cycle divide-by-ten step of the scan engine.
// Reset is synchronous and active low; the count resets to zero.
// A two-entry queue lets the front keep taking items while results stall.
// ----------------------------------------------------------------------------
module counter_seven_segment_scan_unit
    import cssu_pkg::*;
#(
    parameter int NUM_DIGITS = 5,
    parameter int COUNT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cssu_in_if.sink    i_item,
    cssu_out_if.source o_result
);

    t_queue_stat           w_stat;
    logic                  w_push;
    logic [COUNT_BITS-1:0] w_push_data;
    logic                  w_pop;
    logic [COUNT_BITS-1:0] w_pop_data;

    cssu_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_stat      (w_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    cssu_queue #(
        .WIDTH (COUNT_BITS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_stat)
    );

    cssu_back #(
        .NUM_DIGITS (NUM_DIGITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .i_pop_data (w_pop_data),
        .o_pop      (w_pop),
        .o_result   (o_result)
    );

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the counter scan unit. A driver feeds sample and
// load items from a queue, and a scoreboard predicts the five-digit scan pass
// that each item yields. A monitor compares every digit result against the
// oldest prediction. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
    import cssu_pkg::*;

    localparam int NUM_DIGITS   = 5;
    localparam int COUNT_BITS   = 16;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int CALM_ITEMS   = 15;
    localparam int RANDOM_ITEMS = 81;

    localparam logic [SEG_BITS-1:0] DIGIT_SEGS [10] = '{
        8'hDD, 8'h50, 8'h9B, 8'hDA, 8'h56, 8'hCE, 8'hCF, 8'h58, 8'hDF, 8'hDE
    };

    typedef struct {
        t_kind                kind;
        logic                 button_level;
        logic [LOAD_BITS-1:0] load_value;
    } t_count_item;

    typedef struct {
        logic [ENABLE_BITS-1:0] enable;
        logic [SEG_BITS-1:0]    segments;
        logic                   last;
    } t_scan_digit;

    logic i_clk;
    logic i_rst_n;

    cssu_in_if  u_item ();
    cssu_out_if u_result ();

    counter_seven_segment_scan_unit #(
        .NUM_DIGITS (NUM_DIGITS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (u_item),
        .o_result (u_result)
    );

    t_count_item           stimulus_items [$];
    t_scan_digit           expected_digits [$];
    logic [COUNT_BITS-1:0] model_count;
    int                    errors;
    int                    items_taken;
    int                    digits_checked;
    int                    cycles;
    int                    in_idle;
    int                    out_idle;
    logic                  quiet;
    logic                  calm;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void add_item(t_kind kind, logic level, logic [LOAD_BITS-1:0] value);
        t_count_item it;
        it.kind         = kind;
        it.button_level = level;
        it.load_value   = value;
        stimulus_items.push_back(it);
    endfunction

    function automatic void predict_scan(t_count_item it);
        logic [COUNT_BITS-1:0] rest;
        t_scan_digit           d;
        if (it.kind == KIND_LOAD) begin
            model_count = it.load_value[COUNT_BITS-1:0];
        end else if (it.button_level == BUTTON_PRESSED) begin
            model_count = model_count + COUNT_BITS'(1);
        end
        rest = model_count;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d.enable   = (i < ENABLE_BITS) ? (ENABLE_BITS'(1) << i) : '0;
            d.segments = DIGIT_SEGS[rest % 10];
            d.last     = (i == NUM_DIGITS - 1);
            rest       = COUNT_BITS'(rest / 10);
            expected_digits.push_back(d);
        end
    endfunction

    task automatic report(string field, int got, int want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, field, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin : drive_items
        logic        next_valid;
        t_count_item cur;
        t_count_item nxt;
        if (!i_rst_n) begin
            model_count   = '0;
            in_idle       = 0;
            quiet         = 1'b0;
            u_item.valid <= 1'b0;
            calm         <= 1'b0;
        end else begin
            if (u_item.valid && u_item.ready) begin
                cur.kind         = t_kind'(u_item.kind);
                cur.button_level = u_item.button_level;
                cur.load_value   = u_item.load_value;
                predict_scan(cur);
                items_taken++;
            end
            if ($urandom_range(0, 39) == 0) begin
                quiet = !quiet;
            end
            calm <= quiet || (stimulus_items.size() < CALM_ITEMS);
            if (!u_item.valid || u_item.ready) begin
                next_valid = 1'b0;
                if (in_idle > 0) begin
                    in_idle--;
                end else if (stimulus_items.size() > 0) begin
                    if (!calm && $urandom_range(0, 4) == 0) begin
                        in_idle = $urandom_range(0, 5);
                    end else begin
                        nxt = stimulus_items.pop_front();
                        u_item.kind         <= nxt.kind;
                        u_item.button_level <= nxt.button_level;
                        u_item.load_value   <= nxt.load_value;
                        next_valid = 1'b1;
                    end
                end
                u_item.valid <= next_valid;
            end
        end
    end

    always @(posedge i_clk) begin : check_digits
        t_scan_digit want;
        logic        next_ready;
        if (!i_rst_n) begin
            out_idle        = 0;
            u_result.ready <= 1'b1;
        end else begin
            if (u_result.valid && u_result.ready) begin
                if (expected_digits.size() == 0) begin
                    report("result with none expected, segments", u_result.segments, 0);
                end else begin
                    want = expected_digits.pop_front();
                    if (u_result.digit_enable !== want.enable) begin
                        report("digit_enable", u_result.digit_enable, want.enable);
                    end
                    if (u_result.segments !== want.segments) begin
                        report("segments", u_result.segments, want.segments);
                    end
                    if (u_result.last !== want.last) begin
                        report("last", u_result.last, want.last);
                    end
                    digits_checked++;
                end
            end
            if (out_idle > 0) begin
                out_idle--;
                next_ready = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_idle   = $urandom_range(0, 5);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            u_result.ready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        int pick;
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        u_item.valid          = 1'b0;
        u_item.kind           = KIND_SAMPLE;
        u_item.button_level   = 1'b1;
        u_item.load_value     = '0;
        u_result.ready        = 1'b0;
        errors                = 0;
        items_taken           = 0;
        digits_checked        = 0;
        cycles                = 0;

        add_item(KIND_SAMPLE, 1'b1, 16'h0000);
        add_item(KIND_SAMPLE, 1'b0, 16'h0000);
        add_item(KIND_LOAD,   1'b1, 16'hFFFF);
        add_item(KIND_SAMPLE, 1'b0, 16'hFFFF);
        add_item(KIND_LOAD,   1'b0, 16'd9);
        add_item(KIND_SAMPLE, 1'b0, 16'h5555);
        add_item(KIND_LOAD,   1'b1, 16'd99);
        add_item(KIND_SAMPLE, 1'b0, 16'hAAAA);
        add_item(KIND_LOAD,   1'b0, 16'd9999);
        add_item(KIND_SAMPLE, 1'b0, 16'h0000);
        add_item(KIND_LOAD,   1'b0, 16'd12345);
        add_item(KIND_SAMPLE, 1'b1, 16'hFFFF);
        add_item(KIND_LOAD,   1'b1, 16'd54321);
        add_item(KIND_LOAD,   1'b1, 16'd60789);
        add_item(KIND_LOAD,   1'b1, 16'd0);
        add_item(KIND_SAMPLE, 1'b1, 16'h1234);
        add_item(KIND_LOAD,   1'b0, 16'd65534);
        add_item(KIND_SAMPLE, 1'b0, 16'h0000);
        add_item(KIND_SAMPLE, 1'b0, 16'h0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3, 4, 5: begin
                    add_item(KIND_SAMPLE, 1'b0, 16'($urandom));
                end
                6: begin
                    add_item(KIND_SAMPLE, 1'b1, 16'($urandom));
                end
                7: begin
                    add_item(KIND_LOAD, 1'($urandom), 16'($urandom_range(0, 65535)));
                end
                8: begin
                    case ($urandom_range(0, 4))
                        0:       add_item(KIND_LOAD, 1'($urandom),
                                          16'(99 - $urandom_range(0, 3)));
                        1:       add_item(KIND_LOAD, 1'($urandom),
                                          16'(999 - $urandom_range(0, 3)));
                        2:       add_item(KIND_LOAD, 1'($urandom),
                                          16'(9999 - $urandom_range(0, 3)));
                        3:       add_item(KIND_LOAD, 1'($urandom),
                                          16'(59999 - $urandom_range(0, 3)));
                        default: add_item(KIND_LOAD, 1'($urandom),
                                          16'(65535 - $urandom_range(0, 3)));
                    endcase
                end
                default: begin
                    add_item(KIND_LOAD, 1'($urandom), 16'($urandom_range(0, 20)));
                end
            endcase
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stimulus_items.size() > 0 || u_item.valid) @(posedge i_clk);
        while (expected_digits.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("summary: %0d sample and load items taken, %0d digit results checked",
                 items_taken, digits_checked);
        $display("summary: %0d mismatches over %0d cycles", errors, cycles);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
